/* src/hkat_pkg.sv */
// Shared constants, codes, types and the bucket lookup of the aggregation table.
package hkat_pkg;

  localparam int BUCKETS     = 17;
  localparam int CHAIN_DEPTH = 8;
  localparam int KEY_BYTES   = 16;
  localparam int HASH_MOD    = 17;

  localparam int SLOTS    = BUCKETS * CHAIN_DEPTH;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int CNT_W    = $clog2(CHAIN_DEPTH + 1);

  // Key bytes folded into the hash per cycle.
  localparam int STEP_BYTES = 4;
  localparam int HASH_STEPS = (KEY_BYTES + STEP_BYTES - 1) / STEP_BYTES;
  localparam int STEP_W     = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

  localparam int KEY_W  = 64;
  localparam int DATE_W = 28;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 16;  // 255 * (1 + ... + 16) fits
  localparam int HASH_W = 5;   // residue mod 17

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_GET    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_ABSENT = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  key_lo;
    logic [KEY_W-1:0]  key_hi;
    logic [DATE_W-1:0] date;
    logic [VAL_W-1:0]  cases;
    logic [VAL_W-1:0]  deaths;
  } slot_entry_t;

  typedef struct packed {
    logic                done;
    logic [BUCKET_W-1:0] bucket;
    logic [KEY_W-1:0]    key_lo;
    logic [KEY_W-1:0]    key_hi;
  } hash_out_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              we;
    logic [SLOT_W-1:0] wr_addr;
    slot_entry_t       wr_data;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_ACT,
    ST_SHIFT,
    ST_DONE
  } state_t;

  function automatic logic [HASH_MOD*BUCKET_W-1:0] build_bucket_lut();
    logic [HASH_MOD*BUCKET_W-1:0] lut;
    lut = '0;
    for (int i = 0; i < HASH_MOD; i++) begin
      lut[i*BUCKET_W +: BUCKET_W] = BUCKET_W'(i % BUCKETS);
    end
    return lut;
  endfunction

  localparam logic [HASH_MOD*BUCKET_W-1:0] BUCKET_LUT = build_bucket_lut();

  function automatic logic [SLOT_W-1:0] slot_addr(logic [BUCKET_W-1:0] b,
                                                  logic [CNT_W-1:0] j);
    return SLOT_W'(int'(b) * CHAIN_DEPTH + int'(j));
  endfunction

endpackage

/* src/hkat_hash.sv */
// Iterative key former and bucket hash: STEP_BYTES (four) key bytes per cycle, then a mod-17 fold.
module hkat_hash (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hkat_pkg::KEY_W-1:0] name_low,
  input  logic [hkat_pkg::KEY_W-1:0] name_high,
  output hkat_pkg::hash_out_t        result
);
  import hkat_pkg::*;

  logic                busy;
  logic                fold;
  logic                done;
  logic [STEP_W-1:0]   step;
  logic [SUM_W-1:0]    sum;
  logic [2*KEY_W-1:0]  name_r;
  logic [2*KEY_W-1:0]  key;
  logic                ended;
  logic [BUCKET_W-1:0] bucket;
  logic [KEY_W-1:0]    key_lo;
  logic [KEY_W-1:0]    key_hi;

  logic [SUM_W-1:0]    sum_next;
  logic [2*KEY_W-1:0]  key_next;
  logic                ended_next;

  logic [8:0]          fold1;
  logic [8:0]          fold2;
  logic [5:0]          fold3;
  logic [HASH_W-1:0]   residue;
  logic [BUCKET_W-1:0] bucket_next;

  always_comb begin : key_step
    int          p;
    logic [3:0]  pos;
    logic [7:0]  bval;
    logic [4:0]  weight;
    logic [12:0] prod;
    sum_next   = sum;
    key_next   = key;
    ended_next = ended;
    for (int b = 0; b < STEP_BYTES; b++) begin
      p      = int'(step) * STEP_BYTES + b;
      pos    = 4'(p);
      bval   = name_r[{pos, 3'b000} +: 8];
      weight = {1'b0, pos} + 5'd1;
      prod   = 13'(bval) * 13'(weight);
      // name ends at the first zero byte or at the key length
      if (p >= KEY_BYTES || bval == 8'd0) begin
        ended_next = 1'b1;
      end
      if (!ended_next) begin
        sum_next                   = sum_next + SUM_W'(prod);
        key_next[{pos, 3'b000} +: 8] = bval;
      end
    end
  end

  // 256 = 1 mod 17 folds the byte halves; 16 = -1 mod 17 folds the nibbles.
  always_comb begin
    fold1       = {1'b0, sum[15:8]} + {1'b0, sum[7:0]};
    fold2       = {8'd0, fold1[8]} + {1'b0, fold1[7:0]};
    fold3       = 6'(fold2[3:0]) + 6'd17 - 6'(fold2[8:4]);
    residue     = (fold3 >= 6'd17) ? HASH_W'(fold3 - 6'd17) : HASH_W'(fold3);
    bucket_next = BUCKET_LUT[residue*BUCKET_W +: BUCKET_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fold <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fold;
      if (start) begin
        busy <= 1'b1;
        fold <= 1'b0;
      end else if (busy && step == STEP_W'(HASH_STEPS - 1)) begin
        busy <= 1'b0;
        fold <= 1'b1;
      end else begin
        fold <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      name_r <= {name_high, name_low};
      step   <= '0;
      sum    <= '0;
      key    <= '0;
      ended  <= 1'b0;
    end else if (busy) begin
      sum   <= sum_next;
      key   <= key_next;
      ended <= ended_next;
      step  <= step + 1'b1;
    end
    if (fold) begin
      bucket <= bucket_next;
      key_lo <= key[KEY_W-1:0];
      key_hi <= key[2*KEY_W-1:KEY_W];
    end
  end

  assign result = '{done: done, bucket: bucket, key_lo: key_lo, key_hi: key_hi};

endmodule

/* src/hkat_slot_ram.sv */
// Slot store: one write port, one registered read port.
module hkat_slot_ram (
  input  logic                  clk,
  input  hkat_pkg::ram_req_t    req,
  output hkat_pkg::slot_entry_t rd_data
);
  import hkat_pkg::*;

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

/* src/hashed_keyed_aggregation_table.sv */
// Top level: hashed keyed aggregation table with per-bucket chains in slot memory.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------------
//  in      | in_valid/in_stall  | kind name_low name_high year month day new_cases
//          |                    | new_deaths
//  out     | out_valid/out_stall| status out_year out_month out_day total_cases total_deaths
//
// One transaction at a time: hash the key, read the bucket's chain one slot at a time until
// a match or its end, update, issue the result; a remove at chain position j then moves
// the rest of the chain down, one slot a cycle.
// Reset clears the per-bucket fill counts; slot contents are never read past a fill count.
// in_stall is high while a transaction is in work; a stalled result stays in its register
// and holds the next one in its final state until the result is taken.
module hashed_keyed_aggregation_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  kind,
  input  logic [hkat_pkg::KEY_W-1:0]  name_low,
  input  logic [hkat_pkg::KEY_W-1:0]  name_high,
  input  logic [13:0]                 year,
  input  logic [6:0]                  month,
  input  logic [6:0]                  day,
  input  logic signed [31:0]          new_cases,
  input  logic signed [31:0]          new_deaths,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [13:0]                 out_year,
  output logic [6:0]                  out_month,
  output logic [6:0]                  out_day,
  output logic signed [31:0]          total_cases,
  output logic signed [31:0]          total_deaths
);
  import hkat_pkg::*;

  state_t            state;
  state_t            state_next;

  logic              start;
  hash_out_t         hres;
  ram_req_t          ram_req;
  slot_entry_t       rd_data;

  logic [CNT_W-1:0]  fill [BUCKETS];

  logic [1:0]        kind_r;
  logic [DATE_W-1:0] date_r;
  logic [VAL_W-1:0]  cases_r;
  logic [VAL_W-1:0]  deaths_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  idx;
  logic              pend;
  logic [CNT_W-1:0]  pend_idx;
  logic              found;
  logic [CNT_W-1:0]  found_idx;
  slot_entry_t       found_entry;
  logic [1:0]        res_status;
  slot_entry_t       res_entry;

  logic              match;
  logic              last_read;
  logic              out_load;
  slot_entry_t       upd_entry;
  slot_entry_t       new_entry;

  assign start    = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  hkat_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .name_low  (name_low),
    .name_high (name_high),
    .result    (hres)
  );

  hkat_slot_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  assign match = pend && rd_data.key_lo == hres.key_lo && rd_data.key_hi == hres.key_hi;
  assign last_read = pend && (pend_idx == cnt_r - 1'b1);
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    upd_entry        = found_entry;
    upd_entry.cases  = found_entry.cases + cases_r;
    upd_entry.deaths = found_entry.deaths + deaths_r;
    if (date_r > found_entry.date) begin
      upd_entry.date = date_r;
    end
    new_entry = '{key_lo: hres.key_lo, key_hi: hres.key_hi, date: date_r,
                  cases: cases_r, deaths: deaths_r};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_HASH;
      end
      ST_HASH: begin
        if (hres.done) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_r == '0 || match || last_read) state_next = ST_ACT;
      end
      ST_ACT: begin
        if (kind_r == KIND_REMOVE && found && (found_idx + 1'b1) < cnt_r) begin
          state_next = ST_SHIFT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (last_read) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_req         = '0;
    ram_req.rd_addr = slot_addr(hres.bucket, idx);
    ram_req.wr_data = rd_data;
    ram_req.wr_addr = slot_addr(hres.bucket, pend_idx - 1'b1);
    unique case (state)
      ST_SCAN: begin
        ram_req.rd_en = (idx < cnt_r);
      end
      ST_ACT: begin
        if (kind_r == KIND_ADD) begin
          if (found) begin
            ram_req.we      = 1'b1;
            ram_req.wr_addr = slot_addr(hres.bucket, found_idx);
            ram_req.wr_data = upd_entry;
          end else if (cnt_r < CNT_W'(CHAIN_DEPTH)) begin
            ram_req.we      = 1'b1;
            ram_req.wr_addr = slot_addr(hres.bucket, cnt_r);
            ram_req.wr_data = new_entry;
          end
        end
      end
      ST_SHIFT: begin
        // read slot k+1 now, write it into slot k next cycle
        ram_req.rd_en = (idx < cnt_r);
        ram_req.we    = pend;
      end
      ST_IDLE, ST_HASH, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
        fill[b] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_ACT) begin
        if (kind_r == KIND_ADD && !found && cnt_r < CNT_W'(CHAIN_DEPTH)) begin
          fill[hres.bucket] <= cnt_r + 1'b1;
        end else if (kind_r == KIND_REMOVE && found) begin
          fill[hres.bucket] <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          kind_r   <= kind;
          date_r   <= {year, month, day};
          cases_r  <= VAL_W'(new_cases);
          deaths_r <= VAL_W'(new_deaths);
        end
      end
      ST_HASH: begin
        if (hres.done) begin
          cnt_r <= fill[hres.bucket];
          idx   <= '0;
          pend  <= 1'b0;
          found <= 1'b0;
        end
      end
      ST_SCAN: begin
        pend     <= ram_req.rd_en;
        pend_idx <= idx;
        if (ram_req.rd_en) idx <= idx + 1'b1;
        if (match) begin
          found       <= 1'b1;
          found_idx   <= pend_idx;
          found_entry <= rd_data;
        end
      end
      ST_ACT: begin
        pend <= 1'b0;
        idx  <= found_idx + 1'b1;
        if (kind_r == KIND_ADD) begin
          if (found) begin
            res_status <= STATUS_OK;
            res_entry  <= upd_entry;
          end else if (cnt_r < CNT_W'(CHAIN_DEPTH)) begin
            res_status <= STATUS_OK;
            res_entry  <= new_entry;
          end else begin
            res_status <= STATUS_FULL;
            res_entry  <= '0;
          end
        end else if (found) begin
          res_status <= STATUS_OK;
          res_entry  <= found_entry;
        end else begin
          res_status <= STATUS_ABSENT;
          res_entry  <= '0;
        end
      end
      ST_SHIFT: begin
        pend     <= ram_req.rd_en;
        pend_idx <= idx;
        if (ram_req.rd_en) idx <= idx + 1'b1;
      end
      ST_DONE: begin
        if (out_load) begin
          status       <= res_status;
          out_year     <= res_entry.date[27:14];
          out_month    <= res_entry.date[13:7];
          out_day      <= res_entry.date[6:0];
          total_cases  <= $signed(res_entry.cases);
          total_deaths <= $signed(res_entry.deaths);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* tb/hashed_keyed_aggregation_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the hashed keyed aggregation table.
module hashed_keyed_aggregation_table_tb;
  import hkat_pkg::*;

  localparam int LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CROWD = 11;
  localparam logic [1:0] KIND_SPARE = 2'd3;  // unused code, behaves as get

  typedef struct {
    logic [1:0] kind;
    logic [127:0] key;  // {name_high, name_low}
    logic [13:0] year;
    logic [6:0] month;
    logic [6:0] day;
    logic [31:0] cases;
    logic [31:0] deaths;
    int gap;
  } txn_t;

  typedef struct packed {
    logic [1:0] status;
    logic [13:0] year;
    logic [6:0] month;
    logic [6:0] day;
    logic [31:0] cases;
    logic [31:0] deaths;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = '0;
  logic [KEY_W-1:0] name_low = '0;
  logic [KEY_W-1:0] name_high = '0;
  logic [13:0] year = '0;
  logic [6:0] month = '0;
  logic [6:0] day = '0;
  logic signed [31:0] new_cases = '0;
  logic signed [31:0] new_deaths = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [13:0] out_year;
  logic [6:0] out_month;
  logic [6:0] out_day;
  logic signed [31:0] total_cases;
  logic signed [31:0] total_deaths;

  hashed_keyed_aggregation_table dut (.*);

  // Table contents as the block should hold them.
  bit tbl_used [SLOTS];
  logic [127:0] tbl_key [SLOTS];
  logic [DATE_W-1:0] tbl_date [SLOTS];
  logic [31:0] tbl_cases [SLOTS];
  logic [31:0] tbl_deaths [SLOTS];

  txn_t pending[$];
  report_t expected_reports[$];
  int errors = 0;
  int items_taken = 0;
  int results_seen = 0;
  int cycles = 0;
  int n_new = 0, n_accum = 0, n_full = 0, n_absent = 0, n_removed = 0;
  bit in_fired, out_fired;
  int in_wait = 0;
  int out_hold = 0;

  initial forever #6 clk = ~clk;

  // Cleans the key (bytes past its end cleared) and returns its bucket.
  function automatic int key_bucket(input logic [127:0] raw, output logic [127:0] clean);
    int sum;
    bit ended;
    sum = 0;
    ended = 1'b0;
    clean = '0;
    for (int i = 0; i < 16; i++) begin
      if (i >= KEY_BYTES || raw[8*i +: 8] == 8'h00) ended = 1'b1;
      if (!ended) begin
        clean[8*i +: 8] = raw[8*i +: 8];
        sum += int'(raw[8*i +: 8]) * (i + 1);
      end
    end
    return (sum % HASH_MOD) % BUCKETS;
  endfunction

  function automatic report_t slot_report(int s);
    return {STATUS_OK, tbl_date[s], tbl_cases[s], tbl_deaths[s]};
  endfunction

  function automatic report_t table_step(input logic [1:0] op, input logic [127:0] raw,
                                         input logic [DATE_W-1:0] date,
                                         input logic [31:0] cases, input logic [31:0] deaths);
    logic [127:0] key;
    int base, hit, spare;
    report_t r;
    base = key_bucket(raw, key) * CHAIN_DEPTH;
    hit = -1;
    spare = -1;
    r = '0;
    for (int j = 0; j < CHAIN_DEPTH; j++) begin
      if (!tbl_used[base + j]) begin
        if (spare < 0) spare = base + j;
      end else if (hit < 0 && tbl_key[base + j] == key) begin
        hit = base + j;
      end
    end
    case (op)
      KIND_ADD: begin
        if (hit >= 0) begin
          tbl_cases[hit] += cases;
          tbl_deaths[hit] += deaths;
          if (date > tbl_date[hit]) tbl_date[hit] = date;
          r = slot_report(hit);
          n_accum++;
        end else if (spare >= 0) begin
          tbl_used[spare] = 1'b1;
          tbl_key[spare] = key;
          tbl_date[spare] = date;
          tbl_cases[spare] = cases;
          tbl_deaths[spare] = deaths;
          r = slot_report(spare);
          n_new++;
        end else begin
          r.status = STATUS_FULL;
          n_full++;
        end
      end
      KIND_REMOVE: begin
        if (hit >= 0) begin
          r = slot_report(hit);
          n_removed++;
          // close the gap: everything behind the hit moves down one slot
          for (int s = hit; s < base + CHAIN_DEPTH - 1; s++) begin
            tbl_used[s] = tbl_used[s + 1];
            tbl_key[s] = tbl_key[s + 1];
            tbl_date[s] = tbl_date[s + 1];
            tbl_cases[s] = tbl_cases[s + 1];
            tbl_deaths[s] = tbl_deaths[s + 1];
          end
          tbl_used[base + CHAIN_DEPTH - 1] = 1'b0;
        end
      end
      default: begin
        if (hit >= 0) r = slot_report(hit);
      end
    endcase
    if (hit < 0 && op != KIND_ADD) begin
      r.status = STATUS_ABSENT;
      n_absent++;
    end
    return r;
  endfunction

  function automatic logic [127:0] rand_name(int len);
    logic [127:0] k;
    k = '0;
    for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // Junk after the terminating zero byte; must not affect hashing or matching.
  function automatic logic [127:0] smear(logic [127:0] k, int len);
    for (int i = len + 1; i < 16; i++) k[8*i +: 8] = 8'($urandom_range(0, 255));
    return k;
  endfunction

  function automatic void queue_txn(logic [1:0] op, logic [127:0] key, logic [13:0] y,
                                    logic [6:0] m, logic [6:0] d, logic [31:0] c,
                                    logic [31:0] dth, int gap);
    txn_t t;
    t.kind = op;
    t.key = key;
    t.year = y;
    t.month = m;
    t.day = d;
    t.cases = c;
    t.deaths = dth;
    t.gap = gap;
    pending.insert(pending.size(), t);
  endfunction

  // Input driver
  always @(negedge clk) begin
    txn_t t;
    if (!rst && (!in_valid || in_fired)) begin
      if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait <= in_wait - 1;
      end else if (pending.size() > 0) begin
        t = pending.pop_front();
        kind <= t.kind;
        name_low <= t.key[63:0];
        name_high <= t.key[127:64];
        year <= t.year;
        month <= t.month;
        day <= t.day;
        new_cases <= t.cases;
        new_deaths <= t.deaths;
        in_valid <= 1'b1;
        in_wait <= t.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure; some stretches run with no stalls at all.
  always @(negedge clk) begin
    if (out_fired)
      out_hold = (((results_seen / 150) % 4) == 1) ? 0 : $urandom_range(0, 6);
    else if (out_valid === 1'b1 && out_hold > 0)
      out_hold--;
    out_stall <= (out_hold != 0);
  end

  // Monitor: predict on accepted input, check on accepted result
  always @(posedge clk) begin
    report_t got, want;
    cycles++;
    in_fired = !rst && in_valid && !in_stall;
    out_fired = !rst && out_valid === 1'b1 && !out_stall;
    if (in_fired) begin
      expected_reports.insert(expected_reports.size(),
                              table_step(kind, {name_high, name_low}, {year, month, day},
                                         new_cases, new_deaths));
      items_taken++;
    end
    if (out_fired) begin
      got = {status, out_year, out_month, out_day, total_cases, total_deaths};
      results_seen++;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result at cycle %0d: status=%0d", cycles, got.status);
      end else begin
        want = expected_reports.pop_front();
        if (got.status !== want.status || got.year !== want.year ||
            got.month !== want.month || got.day !== want.day ||
            got.cases !== want.cases || got.deaths !== want.deaths) begin
          errors++;
          if (errors <= 10)
            $display("mismatch %0d: want %0d %0d/%0d/%0d %0d %0d, got %0d %0d/%0d/%0d %0d %0d",
                     results_seen, want.status, want.year, want.month, want.day,
                     $signed(want.cases), $signed(want.deaths), got.status, got.year,
                     got.month, got.day, $signed(got.cases), $signed(got.deaths));
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_reports.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [127:0] key_a, key_b, key_void, clean;
    logic [127:0] pool_key[$], crowd_key[$];
    int pool_len[$], crowd_len[$];
    int target, len, roll, gap, idx;
    bit from_crowd;
    logic [1:0] op;
    logic [127:0] key;
    logic [13:0] y;
    logic [6:0] m, d;
    logic [31:0] c, dth;

    key_a = rand_name(5);
    key_b = '1;
    key_void = {$urandom, $urandom, $urandom, 24'($urandom), 8'h00};
    target = $urandom_range(0, BUCKETS - 1);
    while (crowd_key.size() < CROWD) begin
      len = $urandom_range(1, 16);
      key = rand_name(len);
      if (key_bucket(key, clean) == target) begin
        crowd_key.insert(crowd_key.size(), key);
        crowd_len.insert(crowd_len.size(), len);
      end
    end
    for (int i = 0; i < 34; i++) begin
      len = $urandom_range(1, 16);
      pool_key.insert(pool_key.size(), rand_name(len));
      pool_len.insert(pool_len.size(), len);
    end

    // Directed: empty lookups, date ordering, wraparound, key forms, full chain, removal.
    queue_txn(KIND_GET, key_a, 0, 0, 0, 0, 0, $urandom_range(0, 6));
    queue_txn(KIND_REMOVE, key_a, 0, 0, 0, 0, 0, $urandom_range(0, 6));
    queue_txn(KIND_ADD, key_a, 2020, 3, 15, 100, 5, $urandom_range(0, 6));
    queue_txn(KIND_ADD, key_a, 2020, 2, 28, 7, 1, $urandom_range(0, 6));
    queue_txn(KIND_ADD, key_a, 2020, 4, 1, 50, 2, $urandom_range(0, 6));
    queue_txn(KIND_ADD, key_a, 2020, 4, 1, 3, 0, $urandom_range(0, 6));
    queue_txn(KIND_ADD, key_a, 2019, 12, 31, 32'h7fff_ffff, 32'h8000_0000,
              $urandom_range(0, 6));
    queue_txn(KIND_ADD, key_a, 0, 0, 0, 32'hffff_ff00, 32'hffff_ffff, 0);
    queue_txn(KIND_GET, smear(key_a, 5), 0, 0, 0, 0, 0, $urandom_range(0, 6));
    queue_txn(KIND_SPARE, key_a, 14'h3fff, 7'h7f, 7'h7f, '1, '1, 0);
    queue_txn(KIND_ADD, key_b, 14'h3fff, 7'h7f, 7'h7f, '1, '1, $urandom_range(0, 6));
    queue_txn(KIND_GET, key_b, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 10; i++)
      queue_txn(KIND_ADD, crowd_key[i], 2021, 1, 7'(i + 1), i * 10, i, $urandom_range(0, 6));
    queue_txn(KIND_REMOVE, crowd_key[3], 0, 0, 0, 0, 0, $urandom_range(0, 6));
    queue_txn(KIND_GET, crowd_key[7], 0, 0, 0, 0, 0, 0);
    queue_txn(KIND_REMOVE, key_b, 0, 0, 0, 0, 0, $urandom_range(0, 6));
    queue_txn(KIND_GET, key_b, 0, 0, 0, 0, 0, 0);
    queue_txn(KIND_ADD, key_void, 2022, 6, 6, 1, 1, $urandom_range(0, 6));
    queue_txn(KIND_GET, {$urandom, $urandom, $urandom, 24'($urandom), 8'h00},
              0, 0, 0, 0, 0, 0);

    // Random: mostly named traffic on a known key set, a crowded bucket among it.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gap = (((n / 200) % 4) == 2) ? 0 : $urandom_range(0, 6);
      roll = $urandom_range(0, 99);
      from_crowd = ($urandom_range(0, 2) == 0);
      if (from_crowd) begin
        idx = $urandom_range(0, CROWD - 1);
        key = crowd_key[idx];
        len = crowd_len[idx];
      end else begin
        idx = $urandom_range(0, pool_key.size() - 1);
        key = pool_key[idx];
        len = pool_len[idx];
      end
      if (len < 15 && $urandom_range(0, 9) < 3) key = smear(key, len);
      if (roll < 52) op = KIND_ADD;
      else if (roll < 75) op = KIND_GET;
      else if (roll < 92) op = KIND_REMOVE;
      else op = KIND_SPARE;
      if ($urandom_range(0, 99) < 85) begin
        y = 14'($urandom_range(2019, 2023));
        m = 7'($urandom_range(1, 12));
        d = 7'($urandom_range(1, 31));
      end else begin
        y = 14'($urandom);
        m = 7'($urandom);
        d = 7'($urandom);
      end
      case ($urandom_range(0, 4))
        0: begin c = -$urandom_range(0, 500); dth = -$urandom_range(0, 50); end
        1: begin c = $urandom; dth = $urandom; end
        default: begin c = $urandom_range(0, 5000); dth = $urandom_range(0, 200); end
      endcase
      if (roll >= 94) begin
        // noise: arbitrary bits in the kind, key and date fields
        op = 2'($urandom);
        key = {$urandom, $urandom, $urandom, $urandom};
        y = 14'($urandom);
        m = 7'($urandom);
        d = 7'($urandom);
      end
      queue_txn(op, key, y, m, d, c, dth, gap);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d transactions in, %0d results checked over %0d cycles", items_taken,
             results_seen, cycles);
    $display("entries: %0d created, %0d accumulated, %0d removed; %0d full chains, %0d absent",
             n_new, n_accum, n_removed, n_full, n_absent);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
